>>> rtl/kstl_pkg.sv
// ----------------------------------------------------------------------------
// kstl_pkg: shared types and constants for the keypad scanner
// key table, lcd command codes and the front-to-back queue entry
// ----------------------------------------------------------------------------
`default_nettype none

package kstl_pkg;

	localparam logic [7:0] CMD_CLEAR       = 8'h01;
	localparam logic [7:0] CMD_ENTRY_INC   = 8'h06;
	localparam logic [7:0] CMD_ENTRY_SHIFT = 8'h07;
	localparam logic [7:0] KEY_CLEAR       = 8'h43;
	localparam logic [7:0] KEY_NONE        = 8'h58;
	localparam logic [7:0] KEY_NO_KEY      = 8'hFF;
	localparam logic [5:0] LINE_LEN_RESET  = 6'd16;

	typedef enum logic [1:0] {
		OP_NONE        = 2'd0,
		OP_CLEAR       = 2'd1,
		OP_DIGIT       = 2'd2,
		OP_SHIFT_DIGIT = 2'd3
	} kstl_op_t;

	typedef struct packed {
		logic [1:0] col;
		kstl_op_t   op;
		logic [7:0] key;
	} kstl_entry_t;

	function automatic logic [7:0] key_lookup(input logic [3:0] idx);
		logic [7:0] k;
		unique case (idx)
			4'd0:    k = 8'h30;
			4'd3:    k = KEY_CLEAR;
			4'd4:    k = 8'h34;
			4'd5:    k = 8'h31;
			4'd8:    k = 8'h37;
			4'd9:    k = 8'h35;
			4'd10:   k = 8'h32;
			4'd12:   k = 8'h39;
			4'd13:   k = 8'h38;
			4'd14:   k = 8'h36;
			4'd15:   k = 8'h33;
			default: k = KEY_NONE;
		endcase
		return k;
	endfunction

endpackage

`default_nettype wire

>>> rtl/keypad_scan_to_lcd_writer.sv
// ----------------------------------------------------------------------------
// keypad_scan_to_lcd_writer: 4x4 keypad scanner driving a character lcd
// Scan channel: scan_valid/scan_stall carry row_sense, the active-low rows
//   sampled for the column driven on the previous tick; one request per tick.
// Result channel: result_valid/result_stall carry next_column, write_valid,
//   is_data, lcd_byte and last; a tick yields one result, or two for a clear
//   or for a digit past the end of the line; last marks the final one.
// Config channel: cfg_valid/cfg_ready write the 6-bit line length; it is
//   always ready.
// A taken tick is written into the queue, and the writer then loads it from
//   there into its output register, which shows the tick's first result.
// Throughput: a tick is taken every cycle while the queue has room; the
//   writer emits one result per cycle while result_stall is low, and a tick
//   with two writes keeps it from taking the next tick until both are out.
// Stall: a stalled result holds its fields; ticks keep entering until the
//   QUEUE_DEPTH-entry queue fills, then scan_stall rises.
// Reset: column 0, no last key, fresh press, empty line, line length 16,
//   queue empty.
// ----------------------------------------------------------------------------
`default_nettype none

module keypad_scan_to_lcd_writer #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [5:0] cfg_data,
	input  wire logic       scan_valid,
	output logic            scan_stall,
	input  wire logic [3:0] row_sense,
	output logic            result_valid,
	input  wire logic       result_stall,
	output logic [1:0]      next_column,
	output logic            write_valid,
	output logic            is_data,
	output logic [7:0]      lcd_byte,
	output logic            last
);
	import kstl_pkg::*;

	kstl_entry_t entry;
	kstl_entry_t head;
	logic        push;
	logic        pop;
	logic        full;
	logic        empty;

	assign cfg_ready  = 1'b1;
	assign scan_stall = full;
	assign push       = scan_valid && !full;

	kstl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.push      (push),
		.row_sense (row_sense),
		.entry     (entry)
	);

	kstl_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (entry),
		.pop       (pop),
		.head      (head),
		.full      (full),
		.empty     (empty)
	);

	kstl_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.empty        (empty),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.next_column  (next_column),
		.write_valid  (write_valid),
		.is_data      (is_data),
		.lcd_byte     (lcd_byte),
		.last         (last)
	);

endmodule

`default_nettype wire

>>> rtl/kstl_front.sv
// ----------------------------------------------------------------------------
// kstl_front: scan tick decoder
// decodes the sensed row, filters repeats and classifies the lcd action
// ----------------------------------------------------------------------------
`default_nettype none

module kstl_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [5:0]           cfg_data,
	input  wire logic                 push,
	input  wire logic [3:0]           row_sense,
	output kstl_pkg::kstl_entry_t     entry
);
	import kstl_pkg::*;

	logic [1:0] col_q;
	logic [7:0] last_key_q;
	logic       pressed_q;
	logic       fresh_q;
	logic [5:0] chars_q;
	logic [5:0] line_len_q;

	logic [3:0] low;
	logic       any_low;
	logic       single;
	logic [1:0] row_idx;
	logic [7:0] key;
	logic       act;
	logic [1:0] nxt;
	kstl_op_t   op;

	assign low     = ~row_sense;
	assign any_low = |low;
	assign nxt     = col_q + 2'd1;

	always_comb begin
		single  = 1'b1;
		row_idx = 2'd0;
		unique case (low)
			4'b0001: row_idx = 2'd0;
			4'b0010: row_idx = 2'd1;
			4'b0100: row_idx = 2'd2;
			4'b1000: row_idx = 2'd3;
			default: single = 1'b0;
		endcase
	end

	assign key = single ? key_lookup({row_idx, col_q}) : KEY_NONE;
	assign act = any_low && ((key != last_key_q) || fresh_q);

	always_comb begin
		op = OP_NONE;
		if (act && key == KEY_CLEAR) begin
			op = OP_CLEAR;
		end else if (act && key != KEY_NONE) begin
			op = (chars_q < line_len_q) ? OP_DIGIT : OP_SHIFT_DIGIT;
		end
	end

	assign entry.col = nxt;
	assign entry.op  = op;
	assign entry.key = key;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_len_q <= LINE_LEN_RESET;
		end else if (cfg_we) begin
			line_len_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= 2'd0;
			last_key_q <= KEY_NO_KEY;
			pressed_q  <= 1'b0;
			fresh_q    <= 1'b1;
			chars_q    <= 6'd0;
		end else if (push) begin
			col_q <= nxt;
			if (any_low) begin
				last_key_q <= key;
			end
			if (nxt == 2'd0) begin
				fresh_q   <= !(pressed_q || any_low);
				pressed_q <= 1'b0;
			end else begin
				pressed_q <= pressed_q || any_low;
			end
			if (op == OP_CLEAR) begin
				chars_q <= 6'd0;
			end else if (op == OP_DIGIT) begin
				chars_q <= chars_q + 6'd1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_sweep_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(push && col_q == 2'd3) |=> !pressed_q)
		else $error("sweep flag not cleared at end of sweep");
	a_clear_resets_line: assert property (@(posedge clk) disable iff (!arst_n)
		(push && op == OP_CLEAR) |=> chars_q == 6'd0)
		else $error("clear did not reset line count");
	a_repeat_filtered: assert property (@(posedge clk) disable iff (!arst_n)
		(push && op != OP_NONE) |-> (fresh_q || key != last_key_q))
		else $error("repeated key acted on without fresh press");
`endif

endmodule

`default_nettype wire

>>> rtl/kstl_fifo.sv
// ----------------------------------------------------------------------------
// kstl_fifo: action queue
// short queue that lets the decoder and the lcd writer stall on their own
// ----------------------------------------------------------------------------
`default_nettype none

module kstl_fifo #(
	parameter int DEPTH = 4
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire kstl_pkg::kstl_entry_t push_data,
	input  wire logic                 pop,
	output kstl_pkg::kstl_entry_t     head,
	output logic                      full,
	output logic                      empty
);
	import kstl_pkg::*;

	localparam int AW = $clog2(DEPTH);

	kstl_entry_t   mem_q [DEPTH];
	logic [AW:0]   wr_q;
	logic [AW:0]   rd_q;
	logic [AW:0]   count;

	assign count = wr_q - rd_q;
	assign full  = (count == DEPTH[AW:0]);
	assign empty = (count == '0);
	assign head  = mem_q[rd_q[AW-1:0]];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q[AW-1:0]] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count <= DEPTH[AW:0])
		else $error("queue count beyond depth");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |-> !full)
		else $error("push into full queue");
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

>>> rtl/kstl_back.sv
// ----------------------------------------------------------------------------
// kstl_back: lcd writer
// expands each queued action into one or two results in an output register
// ----------------------------------------------------------------------------
`default_nettype none

module kstl_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire kstl_pkg::kstl_entry_t head,
	input  wire logic                 empty,
	output logic                      pop,
	output logic                      result_valid,
	input  wire logic                 result_stall,
	output logic [1:0]                next_column,
	output logic                      write_valid,
	output logic                      is_data,
	output logic [7:0]                lcd_byte,
	output logic                      last
);
	import kstl_pkg::*;

	logic        valid_q;
	logic        pend_q;
	kstl_entry_t held_q;
	logic [1:0]  col_q;
	logic        wv_q;
	logic        data_q;
	logic [7:0]  byte_q;
	logic        last_q;
	logic        load_ok;

	assign load_ok = !valid_q || !result_stall;
	assign pop     = load_ok && !pend_q && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pend_q  <= 1'b0;
		end else if (load_ok) begin
			if (pend_q) begin
				valid_q <= 1'b1;
				pend_q  <= 1'b0;
			end else if (!empty) begin
				valid_q <= 1'b1;
				pend_q  <= (head.op == OP_CLEAR) || (head.op == OP_SHIFT_DIGIT);
			end else begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_ok) begin
			if (pend_q) begin
				wv_q   <= 1'b1;
				last_q <= 1'b1;
				if (held_q.op == OP_CLEAR) begin
					data_q <= 1'b0;
					byte_q <= CMD_ENTRY_INC;
				end else begin
					data_q <= 1'b1;
					byte_q <= held_q.key;
				end
			end else if (!empty) begin
				held_q <= head;
				col_q  <= head.col;
				unique case (head.op)
					OP_NONE: begin
						wv_q   <= 1'b0;
						data_q <= 1'b0;
						byte_q <= 8'h00;
						last_q <= 1'b1;
					end
					OP_CLEAR: begin
						wv_q   <= 1'b1;
						data_q <= 1'b0;
						byte_q <= CMD_CLEAR;
						last_q <= 1'b0;
					end
					OP_DIGIT: begin
						wv_q   <= 1'b1;
						data_q <= 1'b1;
						byte_q <= head.key;
						last_q <= 1'b1;
					end
					OP_SHIFT_DIGIT: begin
						wv_q   <= 1'b1;
						data_q <= 1'b0;
						byte_q <= CMD_ENTRY_SHIFT;
						last_q <= 1'b0;
					end
					default: begin
						wv_q   <= 1'b0;
						data_q <= 1'b0;
						byte_q <= 8'h00;
						last_q <= 1'b1;
					end
				endcase
			end
		end
	end

	assign result_valid = valid_q;
	assign next_column  = col_q;
	assign write_valid  = wv_q;
	assign is_data      = data_q;
	assign lcd_byte     = byte_q;
	assign last         = last_q;

`ifndef NO_ASSERTIONS
	a_pend_shows_first: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (valid_q && !last_q))
		else $error("second write pending without first shown");
	a_first_has_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !last_q) |-> pend_q)
		else $error("non-final result without second pending");
	a_second_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !result_stall && !last_q) |=> (valid_q && last_q))
		else $error("second write did not follow the first");
`endif

endmodule

`default_nettype wire
